@@ sv/ccre_pkg.sv @@
// Shared types and constants of the character-cell raster engine.
package ccre_pkg;

  localparam logic [2:0] OP_PLOT      = 3'd0;
  localparam logic [2:0] OP_PLOT_TRAN = 3'd1;
  localparam logic [2:0] OP_FILL      = 3'd2;
  localparam logic [2:0] OP_BORDER    = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;

  localparam logic [0:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [7:0] SPACE_GLYPH = 8'd32;

  localparam logic [7:0] RESET_FRAME_WIDTH  = 8'd80;
  localparam logic [6:0] RESET_FRAME_HEIGHT = 7'd25;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_RUN  = 1'b1;

  typedef struct packed {
    logic [7:0] color;
    logic [7:0] glyph;
  } cell_t;

  typedef struct packed {
    logic  wr_en;
    logic  done;
    logic  busy;
  } sweep_stat_t;

endpackage

@@ sv/ccre_cell_mem.sv @@
// Single-port-write, single-port-read cell memory with a registered read.
module ccre_cell_mem #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  ccre_pkg::cell_t      wr_cell,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output ccre_pkg::cell_t      rd_cell
);

  ccre_pkg::cell_t mem [DEPTH];
  ccre_pkg::cell_t rd_cell_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_cell;
    end
    if (rd_en) begin
      rd_cell_r <= mem[rd_addr];
    end
  end

  assign rd_cell = rd_cell_r;

endmodule

@@ sv/ccre_sweep.sv @@
// Cell walker that steps through a fill rectangle or the frame border, one cell a cycle.
module ccre_sweep #(
  parameter int CW = 8,
  parameter int RW = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  border,
  input  logic [CW-1:0]         x0,
  input  logic [CW-1:0]         x1,
  input  logic [RW-1:0]         y0,
  input  logic [RW-1:0]         y1,
  input  logic [CW-1:0]         w,
  input  logic [RW-1:0]         h,
  input  ccre_pkg::cell_t       src_cell,
  output ccre_pkg::sweep_stat_t stat,
  output logic [CW-1:0]         col,
  output logic [RW-1:0]         row,
  output ccre_pkg::cell_t       wr_cell
);

  logic [0:0]      state_r, state_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [CW-1:0]   x0_r, x1_r, w_r;
  logic [RW-1:0]   y1_r, h_r;
  logic            border_r;
  ccre_pkg::cell_t cell_r;

  logic            run;
  logic            edge_row;
  logic            row_end;
  logic            last_row;
  logic [CW-1:0]   col_step;
  logic [CW-1:0]   col_first;

  always_comb begin
    run      = (state_r == ccre_pkg::ST_RUN);
    edge_row = (row_r == '0) || (row_r == h_r - RW'(1));
    if (border_r) begin
      row_end   = (col_r == w_r - CW'(1));
      col_step  = edge_row ? col_r + CW'(1) : w_r - CW'(1);
      col_first = '0;
      last_row  = (row_r == h_r - RW'(1));
    end else begin
      row_end   = (col_r + CW'(1) == x1_r);
      col_step  = col_r + CW'(1);
      col_first = x0_r;
      last_row  = (row_r + RW'(1) == y1_r);
    end

    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    if (run) begin
      if (row_end) begin
        col_nxt = col_first;
        row_nxt = row_r + RW'(1);
        if (last_row) begin
          state_nxt = ccre_pkg::ST_IDLE;
        end
      end else begin
        col_nxt = col_step;
      end
    end else if (start) begin
      state_nxt = ccre_pkg::ST_RUN;
      col_nxt   = border ? '0 : x0;
      row_nxt   = border ? '0 : y0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ccre_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    col_r <= col_nxt;
    row_r <= row_nxt;
    if (!run && start) begin
      border_r <= border;
      x0_r     <= x0;
      x1_r     <= x1;
      y1_r     <= y1;
      w_r      <= w;
      h_r      <= h;
      cell_r   <= border ? ccre_pkg::cell_t'{color: src_cell.color,
                                             glyph: ccre_pkg::SPACE_GLYPH}
                         : src_cell;
    end
  end

  assign stat.wr_en = run;
  assign stat.done  = run && row_end && last_row;
  assign stat.busy  = run;
  assign col        = col_r;
  assign row        = row_r;
  assign wr_cell    = cell_r;

endmodule

@@ sv/char_cell_raster_engine.sv @@
// Top level of the character-cell raster engine: command intake, result register, memory.
//
// Commands arrive as words on the in_ stream: in_tuser carries the operation and in_tdata
// the coordinates, glyph and color. Every command returns exactly one word on the out_
// stream: read glyph and color in out_tdata and the in-bounds flag in out_tuser.
// The result of a plot or read is offered in the cycle after acceptance; the read data
// comes from the registered port of the cell memory, so back-to-back plots and reads
// run at one word per cycle while out_tready stays high.
// A fill or border writes one cell per cycle through the single write port of the cell
// memory and holds in_tready low while it writes; the result word follows the last write.
// The frame size registers are written through cfg_we, cfg_index and cfg_wdata.
// Reset sets the frame to 80 by 25 and empties the result register; cell contents
// are undefined until written. When out_tready is low while a result word is offered,
// the word holds and no new command is taken.
module char_cell_raster_engine #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // x_pos, y_pos, x_end, y_end, glyph, color
  input  logic [2:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // read_glyph, read_color
  output logic [0:0]  out_tuser,  // in_bounds
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int CW    = $clog2(MAX_COLUMNS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]  frame_width_r;
  logic [6:0]  frame_height_r;

  logic        out_valid_r, out_valid_nxt;
  logic        out_rd_r, out_rd_nxt;
  logic        out_ib_r, out_ib_nxt;

  logic [2:0]  op;
  logic [15:0] x_pos, y_pos, x_end, y_end;
  ccre_pkg::cell_t in_cell;

  logic [CW-1:0] w;
  logic [RW-1:0] h;
  logic          in_frame;
  logic [CW-1:0] cx0, cx1;
  logic [RW-1:0] cy0, cy1;
  logic          accept;
  logic          fill_go, border_go, sweep_go;
  logic          plot_wr;

  ccre_pkg::sweep_stat_t sweep_stat;
  logic [CW-1:0]   sweep_col;
  logic [RW-1:0]   sweep_row;
  ccre_pkg::cell_t sweep_cell;

  logic            mem_wr_en;
  logic [AW-1:0]   mem_wr_addr;
  ccre_pkg::cell_t mem_wr_cell;
  logic            mem_rd_en;
  logic [AW-1:0]   plot_addr;
  logic [AW-1:0]   sweep_addr;
  ccre_pkg::cell_t mem_rd_cell;

  assign op            = in_tuser;
  assign x_pos         = in_tdata[15:0];
  assign y_pos         = in_tdata[31:16];
  assign x_end         = in_tdata[47:32];
  assign y_end         = in_tdata[63:48];
  assign in_cell.glyph = in_tdata[71:64];
  assign in_cell.color = in_tdata[79:72];

  always_comb begin
    w = (32'(frame_width_r) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(frame_width_r);
    h = (32'(frame_height_r) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(frame_height_r);

    in_frame = !x_pos[15] && (x_pos < 16'(w)) && !y_pos[15] && (y_pos < 16'(h));

    cx0 = x_pos[15] ? '0 : ((x_pos > 16'(w)) ? w : CW'(x_pos));
    cx1 = x_end[15] ? '0 : ((x_end > 16'(w)) ? w : CW'(x_end));
    cy0 = y_pos[15] ? '0 : ((y_pos > 16'(h)) ? h : RW'(y_pos));
    cy1 = y_end[15] ? '0 : ((y_end > 16'(h)) ? h : RW'(y_end));

    in_tready = !sweep_stat.busy && (!out_valid_r || out_tready);
    accept    = in_tvalid && in_tready;

    fill_go   = accept && (op == ccre_pkg::OP_FILL) && (cx0 < cx1) && (cy0 < cy1);
    border_go = accept && (op == ccre_pkg::OP_BORDER) && (w != '0) && (h != '0);
    sweep_go  = fill_go || border_go;

    plot_wr = accept && in_frame &&
              ((op == ccre_pkg::OP_PLOT) ||
               ((op == ccre_pkg::OP_PLOT_TRAN) && (in_cell.glyph != ccre_pkg::SPACE_GLYPH)));

    mem_rd_en = accept && (op == ccre_pkg::OP_READ) && in_frame;

    plot_addr  = AW'(32'(RW'(y_pos)) * MAX_COLUMNS + 32'(CW'(x_pos)));
    sweep_addr = AW'(32'(sweep_row) * MAX_COLUMNS + 32'(sweep_col));

    mem_wr_en   = plot_wr || sweep_stat.wr_en;
    mem_wr_addr = sweep_stat.wr_en ? sweep_addr : plot_addr;
    mem_wr_cell = sweep_stat.wr_en ? sweep_cell : in_cell;

    out_valid_nxt = out_valid_r && !out_tready;
    out_rd_nxt    = out_rd_r;
    out_ib_nxt    = out_ib_r;
    if (sweep_stat.done) begin
      out_valid_nxt = 1'b1;
      out_rd_nxt    = 1'b0;
      out_ib_nxt    = 1'b0;
    end else if (accept && !sweep_go) begin
      out_valid_nxt = 1'b1;
      out_rd_nxt    = mem_rd_en;
      case (op)
        ccre_pkg::OP_PLOT, ccre_pkg::OP_PLOT_TRAN, ccre_pkg::OP_READ: out_ib_nxt = in_frame;
        default: out_ib_nxt = 1'b0;
      endcase
    end else if (accept) begin
      out_rd_nxt = 1'b0;
      out_ib_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= ccre_pkg::RESET_FRAME_WIDTH;
      frame_height_r <= ccre_pkg::RESET_FRAME_HEIGHT;
      out_valid_r    <= 1'b0;
      out_rd_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ccre_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
          ccre_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[6:0];
          default: ;
        endcase
      end
      out_valid_r <= out_valid_nxt;
      out_rd_r    <= out_rd_nxt;
    end
    out_ib_r <= out_ib_nxt;
  end

  ccre_sweep #(
    .CW (CW),
    .RW (RW)
  ) u_sweep (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sweep_go),
    .border   (border_go),
    .x0       (cx0),
    .x1       (cx1),
    .y0       (cy0),
    .y1       (cy1),
    .w        (w),
    .h        (h),
    .src_cell (in_cell),
    .stat     (sweep_stat),
    .col      (sweep_col),
    .row      (sweep_row),
    .wr_cell  (sweep_cell)
  );

  ccre_cell_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_cell (mem_wr_cell),
    .rd_en   (mem_rd_en),
    .rd_addr (plot_addr),
    .rd_cell (mem_rd_cell)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_rd_r ? {mem_rd_cell.color, mem_rd_cell.glyph} : 16'h0000;
  assign out_tuser  = out_ib_r;

endmodule

@@ tb/char_cell_raster_engine_tb.sv @@
// Self-checking testbench of the character-cell raster engine, built around a shadow frame model.
module char_cell_raster_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS  = 128;
  localparam int ROWS  = 64;
  localparam int CELLS = COLS * ROWS;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_MID   = 3'd6;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  localparam int PHASES      = 7;
  localparam int PHASE_WORDS = 250;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic signed [15:0] x_end;
    logic signed [15:0] y_end;
    logic [7:0]         glyph;
    logic [7:0]         color;
  } command_t;

  typedef struct packed {
    logic [7:0] read_glyph;
    logic [7:0] read_color;
    logic       in_bounds;
  } cell_result_t;

  class frame_shadow;
    logic [7:0]   glyphs [CELLS];
    logic [7:0]   colors [CELLS];
    logic [7:0]   width_reg;
    logic [6:0]   height_reg;
    cell_result_t expected_words [$];
    int           mismatches;

    function new();
      width_reg  = ccre_pkg::RESET_FRAME_WIDTH;
      height_reg = ccre_pkg::RESET_FRAME_HEIGHT;
      mismatches = 0;
    endfunction

    function void write_register(logic [0:0] index, logic [7:0] value);
      if (index == ccre_pkg::REG_FRAME_WIDTH) begin
        width_reg = value;
      end else begin
        height_reg = value[6:0];
      end
    endfunction

    function int cols();
      return (width_reg > COLS) ? COLS : int'(width_reg);
    endfunction

    function int rows();
      return (height_reg > ROWS) ? ROWS : int'(height_reg);
    endfunction

    function bit in_frame(int x, int y);
      return x >= 0 && x < cols() && y >= 0 && y < rows();
    endfunction

    function void put_cell(int x, int y, logic [7:0] g, logic [7:0] c);
      if (in_frame(x, y)) begin
        glyphs[x + y * COLS] = g;
        colors[x + y * COLS] = c;
      end
    endfunction

    function int clamp(int v, int hi);
      if (v < 0) return 0;
      return (v > hi) ? hi : v;
    endfunction

    function void apply_command(command_t cmd);
      cell_result_t res;
      int x, y, x0, x1, y0, y1, w, h;
      res = '0;
      x = $signed(cmd.x_pos);
      y = $signed(cmd.y_pos);
      w = cols();
      h = rows();
      case (cmd.op)
        ccre_pkg::OP_PLOT: begin
          res.in_bounds = in_frame(x, y);
          put_cell(x, y, cmd.glyph, cmd.color);
        end
        ccre_pkg::OP_PLOT_TRAN: begin
          res.in_bounds = in_frame(x, y);
          if (cmd.glyph != ccre_pkg::SPACE_GLYPH) put_cell(x, y, cmd.glyph, cmd.color);
        end
        ccre_pkg::OP_FILL: begin
          x0 = clamp(x, w);
          x1 = clamp($signed(cmd.x_end), w);
          y0 = clamp(y, h);
          y1 = clamp($signed(cmd.y_end), h);
          for (int i = x0; i < x1; i++)
            for (int j = y0; j < y1; j++)
              put_cell(i, j, cmd.glyph, cmd.color);
        end
        ccre_pkg::OP_BORDER: begin
          for (int i = 0; i < w; i++)
            for (int j = 0; j < h; j++)
              if (i == 0 || j == 0 || i == w - 1 || j == h - 1)
                put_cell(i, j, ccre_pkg::SPACE_GLYPH, cmd.color);
        end
        ccre_pkg::OP_READ: begin
          if (in_frame(x, y)) begin
            res.in_bounds  = 1'b1;
            res.read_glyph = glyphs[x + y * COLS];
            res.read_color = colors[x + y * COLS];
          end
        end
        default: ;
      endcase
      expected_words.push_back(res);
    endfunction

    function void compare_word(logic [7:0] g, logic [7:0] c, logic ib);
      cell_result_t exp_word;
      if (expected_words.size() == 0) begin
        mismatches++;
        $error("result word with no command waiting: read_glyph %0d read_color %0d in_bounds %0d",
               g, c, ib);
        return;
      end
      exp_word = expected_words.pop_front();
      if (exp_word.read_glyph !== g) begin
        mismatches++;
        $error("read_glyph: expected %0d, actual %0d", exp_word.read_glyph, g);
      end
      if (exp_word.read_color !== c) begin
        mismatches++;
        $error("read_color: expected %0d, actual %0d", exp_word.read_color, c);
      end
      if (exp_word.in_bounds !== ib) begin
        mismatches++;
        $error("in_bounds: expected %0d, actual %0d", exp_word.in_bounds, ib);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;   // x_pos, y_pos, x_end, y_end, glyph, color
  logic [2:0]  in_tuser;   // operation
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // read_glyph, read_color
  logic [0:0]  out_tuser;  // in_bounds
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  frame_shadow shadow;
  int          gap_level;
  int          stall_level;

  char_cell_raster_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    command_t seen;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        seen.op    = in_tuser;
        seen.x_pos = in_tdata[15:0];
        seen.y_pos = in_tdata[31:16];
        seen.x_end = in_tdata[47:32];
        seen.y_end = in_tdata[63:48];
        seen.glyph = in_tdata[71:64];
        seen.color = in_tdata[79:72];
        shadow.apply_command(seen);
      end
      if (out_tvalid && out_tready)
        shadow.compare_word(out_tdata[7:0], out_tdata[15:8], out_tuser[0]);
    end
  end

  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_level != 0 && $urandom_range(0, stall_level == 1 ? 11 : 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic hold_input(int cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic send_command(command_t cmd);
    if (gap_level != 0 && $urandom_range(0, gap_level == 1 ? 11 : 3) == 0)
      hold_input($urandom_range(1, 14));
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd.op;
    in_tdata  <= {cmd.color, cmd.glyph, cmd.y_end, cmd.x_end, cmd.y_pos, cmd.x_pos};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic issue(logic [2:0] op, int x, int y, int xe, int ye,
                       logic [7:0] g, logic [7:0] c);
    command_t cmd;
    cmd.op    = op;
    cmd.x_pos = 16'(x);
    cmd.y_pos = 16'(y);
    cmd.x_end = 16'(xe);
    cmd.y_end = 16'(ye);
    cmd.glyph = g;
    cmd.color = c;
    send_command(cmd);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (shadow.expected_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_frame(logic [7:0] width, logic [7:0] height);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= ccre_pkg::REG_FRAME_WIDTH;
    cfg_wdata <= width;
    @(negedge clk);
    cfg_index <= ccre_pkg::REG_FRAME_HEIGHT;
    cfg_wdata <= height;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow.write_register(ccre_pkg::REG_FRAME_WIDTH, width);
    shadow.write_register(ccre_pkg::REG_FRAME_HEIGHT, height);
  endtask

  function automatic logic [15:0] pick_coord(int limit);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70 && limit > 0) return 16'($urandom_range(0, limit - 1));
    if (r < 88) return 16'(int'($urandom_range(0, limit + 6)) - 3);
    return 16'($urandom);
  endfunction

  function automatic command_t random_command();
    command_t cmd;
    int r, x0, y0;
    r = $urandom_range(0, 99);
    cmd.x_end = 16'($urandom);
    cmd.y_end = 16'($urandom);
    cmd.glyph = ($urandom_range(0, 3) == 0) ? ccre_pkg::SPACE_GLYPH : 8'($urandom);
    cmd.color = 8'($urandom);
    cmd.x_pos = pick_coord(shadow.cols());
    cmd.y_pos = pick_coord(shadow.rows());
    if (r < 25) begin
      cmd.op = ccre_pkg::OP_PLOT;
    end else if (r < 45) begin
      cmd.op = ccre_pkg::OP_PLOT_TRAN;
    end else if (r < 75) begin
      cmd.op = ccre_pkg::OP_READ;
    end else if (r < 87) begin
      cmd.op = ccre_pkg::OP_FILL;
      r = $urandom_range(0, 99);
      if (r < 90) begin
        x0 = int'($urandom_range(0, shadow.cols() + 5)) - 3;
        y0 = int'($urandom_range(0, shadow.rows() + 5)) - 3;
        cmd.x_pos = 16'(x0);
        cmd.y_pos = 16'(y0);
        cmd.x_end = 16'(x0 + int'($urandom_range(0, 8)) - 2);
        cmd.y_end = 16'(y0 + int'($urandom_range(0, 8)) - 2);
      end else if (r < 98) begin
        cmd.x_pos = 16'($urandom);
        cmd.y_pos = 16'($urandom);
      end else begin
        cmd.x_pos = 16'h8000;
        cmd.y_pos = 16'h8000;
        cmd.x_end = 16'h7FFF;
        cmd.y_end = 16'h7FFF;
      end
    end else if (r < 92) begin
      cmd.op = ccre_pkg::OP_BORDER;
    end else begin
      cmd.op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    end
    return cmd;
  endfunction

  initial begin
    shadow      = new();
    gap_level   = 0;
    stall_level = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    issue(ccre_pkg::OP_PLOT, 79, 24, 0, 0, 8'h5A, 8'h1F);
    issue(ccre_pkg::OP_PLOT, 80, 24, -1, -1, 8'hFF, 8'hFF);
    issue(ccre_pkg::OP_READ, 79, 24, 0, 0, 8'h00, 8'h00);

    set_frame(8'd128, 8'd64);
    // Every cell gets a known value before the first read of the full store.
    issue(ccre_pkg::OP_FILL, -32768, -32768, 32767, 32767, 8'h2E, 8'h07);
    issue(ccre_pkg::OP_PLOT, 0, 0, -32768, -32768, 8'h00, 8'hFF);
    issue(ccre_pkg::OP_PLOT, 127, 63, 32767, 32767, 8'hFF, 8'h00);
    issue(ccre_pkg::OP_PLOT, 128, 0, 0, 0, 8'h11, 8'h22);
    issue(ccre_pkg::OP_PLOT, -32768, 32767, 0, 0, 8'h33, 8'h44);
    issue(ccre_pkg::OP_READ, 0, 0, 0, 0, 8'h00, 8'h00);
    issue(ccre_pkg::OP_READ, 127, 63, 0, 0, 8'h00, 8'h00);
    issue(ccre_pkg::OP_READ, -1, 0, 0, 0, 8'h00, 8'h00);
    issue(ccre_pkg::OP_PLOT_TRAN, 5, 5, 0, 0, ccre_pkg::SPACE_GLYPH, 8'hAA);
    issue(ccre_pkg::OP_READ, 5, 5, 0, 0, 8'h00, 8'h00);
    issue(ccre_pkg::OP_PLOT_TRAN, 5, 5, 0, 0, 8'h41, 8'h55);
    issue(ccre_pkg::OP_READ, 5, 5, 0, 0, 8'h00, 8'h00);
    issue(ccre_pkg::OP_FILL, 10, 10, 5, 5, 8'h58, 8'h01);
    issue(ccre_pkg::OP_FILL, 3, 3, 3, 9, 8'h59, 8'h02);
    issue(ccre_pkg::OP_FILL, 126, 62, 32767, 32767, 8'h5B, 8'h03);
    issue(ccre_pkg::OP_READ, 127, 63, 0, 0, 8'h00, 8'h00);
    issue(ccre_pkg::OP_BORDER, 0, 0, 0, 0, 8'h00, 8'h3C);
    issue(ccre_pkg::OP_READ, 0, 10, 0, 0, 8'h00, 8'h00);
    issue(OP_SPARE_FIRST, -1, -1, -1, -1, 8'hFF, 8'hFF);
    issue(OP_SPARE_MID, 1, 1, 1, 1, 8'hFF, 8'hFF);
    issue(OP_SPARE_LAST, 0, 0, 0, 0, 8'h00, 8'h00);

    set_frame(8'd1, 8'd1);
    issue(ccre_pkg::OP_BORDER, 0, 0, 0, 0, 8'h00, 8'h81);
    issue(ccre_pkg::OP_READ, 0, 0, 0, 0, 8'h00, 8'h00);
    issue(ccre_pkg::OP_READ, 1, 0, 0, 0, 8'h00, 8'h00);

    set_frame(8'd0, 8'd0);
    issue(ccre_pkg::OP_PLOT, 0, 0, 0, 0, 8'h42, 8'h42);
    issue(ccre_pkg::OP_FILL, -32768, -32768, 32767, 32767, 8'h43, 8'h43);
    issue(ccre_pkg::OP_BORDER, 0, 0, 0, 0, 8'h00, 8'h44);
    issue(ccre_pkg::OP_READ, 0, 0, 0, 0, 8'h00, 8'h00);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_frame(ccre_pkg::RESET_FRAME_WIDTH, 8'(ccre_pkg::RESET_FRAME_HEIGHT));
        1: set_frame(8'd128, 8'd64);
        2: set_frame(8'd1, 8'd1);
        3: set_frame(8'($urandom_range(1, 128)), 8'($urandom_range(1, 64)));
        4: set_frame(8'hFF, 8'hFF);
        5: set_frame(8'h00, 8'h80);
        default: set_frame(8'($urandom), 8'($urandom));
      endcase
      if (phase == PHASES - 1) begin
        gap_level   = 0;
        stall_level = 0;
      end else begin
        gap_level   = $urandom_range(0, 2);
        stall_level = $urandom_range(0, 2);
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n == PHASE_WORDS / 2) drain_results();
        send_command(random_command());
      end
    end

    drain_results();
    repeat (16) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.expected_words.size() == 0) begin
      $display("char_cell_raster_engine verification clean");
    end else begin
      $display("char_cell_raster_engine verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("char_cell_raster_engine verification failed");
    $finish;
  end

endmodule
